// ----- rtl/aeb_pkg.sv -----
package aeb_pkg;

    localparam int unsigned DATA_W = 8;
    localparam logic [15:0] TRIGGER_RESET = 16'd16384;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_PULL  = 2'd1,
        REQ_START = 2'd2,
        REQ_STOP  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        MODE_READY   = 2'd0,
        MODE_PRELOAD = 2'd1,
        MODE_PLAY    = 2'd2,
        MODE_DROP    = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_TRIGGERED = 3'd1,
        EV_HEALED    = 3'd2,
        EV_OVERFLOW  = 3'd3,
        EV_UNDERFLOW = 3'd4,
        EV_DISCARDED = 3'd5,
        EV_REFUSED   = 3'd6
    } t_event;

    typedef struct packed {
        logic        byte_valid;
        t_mode       mode;
        t_event      event_code;
        logic [15:0] fill_level;
        logic [31:0] dropped_count;
        logic        output_enable;
    } t_status;

endpackage

// ----- rtl/audio_elastic_buffer_ctrl_core.sv -----
// Audio elastic buffer: a byte FIFO with preload between a bursty chunk
// producer and an output device.
// Input channel (i_in_valid / o_in_stall): one request per transfer, either a
// pushed byte with its chunk markers, a pull, start or stop-and-flush.
// Output channel (o_out_valid / i_out_stall): exactly one result per request,
// carrying the pulled byte, mode, event, fill level, drop count and the
// output enable as they stand after that request.
// Throughput: one request per cycle while o_in_stall is low. Each request is
// resolved in the cycle it is taken; the byte store sees at most one write or
// one read per request. A result is held in the middle stage, written together
// with the synchronous store read, and then in the output register.
// A stalled receiver holds the output register; one more result waits in the
// middle stage, and only then is the input stalled.
// Reset clears pointers, fill, mode (ready), drop count, output enable and
// loads the trigger level with 16384. The byte store is not cleared; only
// bytes that were pushed are ever read back. The trigger register may be
// written at any cycle while no request is in flight.
module audio_elastic_buffer_ctrl_core
    import aeb_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic        i_chunk_first,
    input  logic        i_chunk_last,
    input  logic [15:0] i_chunk_size,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_byte_valid,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_play_mode,
    output logic [2:0]  o_event_code,
    output logic [15:0] o_fill_level,
    output logic [31:0] o_dropped_count,
    output logic        o_output_enable
);

    localparam int unsigned AW = $clog2(BUFFER_BYTES);
    localparam int unsigned FW = $clog2(BUFFER_BYTES + 1);
    localparam int unsigned CW = (FW > 16) ? FW : 16;

    logic [AW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [FW-1:0]     r_fill, n_fill;
    t_mode             r_mode, n_mode;
    logic [31:0]       r_drop, n_drop;
    logic              r_chunk_ok, n_chunk_ok;
    logic              r_out_en, n_out_en;
    logic [15:0]       r_trigger;

    logic              r_s1_valid;
    t_status           r_s1, n_s1;
    logic              r_o_valid;
    t_status           r_o;
    logic [DATA_W-1:0] r_o_byte;

    logic              accept;
    logic              s1_move;
    logic              mem_we;
    logic              mem_re;
    logic [DATA_W-1:0] mem_rdata;
    t_event            ev;
    logic              bv;

    logic [CW-1:0]     fill_x;
    logic [CW-1:0]     trig_x;
    logic [CW-1:0]     free_x;
    logic [CW-1:0]     n_fill_x;
    logic [32:0]       drop_sum;

    assign s1_move    = r_s1_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign accept     = i_in_valid && !o_in_stall;

    assign fill_x   = CW'(r_fill);
    assign trig_x   = CW'(r_trigger);
    assign free_x   = CW'(FW'(BUFFER_BYTES) - r_fill);
    assign n_fill_x = CW'(n_fill);
    assign drop_sum = {1'b0, r_drop} + 33'(i_chunk_size);

    always_comb begin
        n_wr_ptr   = r_wr_ptr;
        n_rd_ptr   = r_rd_ptr;
        n_fill     = r_fill;
        n_mode     = r_mode;
        n_drop     = r_drop;
        n_chunk_ok = r_chunk_ok;
        n_out_en   = r_out_en;
        ev         = EV_NONE;
        bv         = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        unique case (t_req'(i_req_type))
            REQ_PUSH: begin
                if (i_chunk_first) begin
                    if (r_mode == MODE_DROP) begin
                        n_drop     = drop_sum[32] ? '1 : drop_sum[31:0];
                        n_chunk_ok = 1'b0;
                        if (fill_x <= trig_x) begin
                            n_mode = MODE_PLAY;
                            ev     = EV_HEALED;
                        end else begin
                            ev = EV_DISCARDED;
                        end
                    end else if (CW'(i_chunk_size) <= free_x) begin
                        n_chunk_ok = 1'b1;
                    end else begin
                        n_chunk_ok = 1'b0;
                        n_mode     = MODE_DROP;
                        n_drop     = '0;
                        ev         = EV_OVERFLOW;
                    end
                end
                if (n_chunk_ok) begin
                    if (r_fill != FW'(BUFFER_BYTES)) begin
                        mem_we   = 1'b1;
                        n_wr_ptr = (r_wr_ptr == AW'(BUFFER_BYTES - 1)) ? '0
                                                                      : r_wr_ptr + 1'b1;
                        n_fill   = r_fill + 1'b1;
                    end else begin
                        // chunk ran past its declared size: lose the byte
                        ev = EV_DISCARDED;
                    end
                    if (i_chunk_last && n_mode == MODE_PRELOAD && n_fill_x >= trig_x) begin
                        n_mode   = MODE_PLAY;
                        n_out_en = 1'b1;
                        ev       = EV_TRIGGERED;
                    end
                end else if (!i_chunk_first) begin
                    ev = EV_DISCARDED;
                end
            end
            REQ_PULL: begin
                if (r_mode == MODE_PLAY || r_mode == MODE_DROP) begin
                    if (r_fill != '0) begin
                        mem_re   = 1'b1;
                        bv       = 1'b1;
                        n_rd_ptr = (r_rd_ptr == AW'(BUFFER_BYTES - 1)) ? '0
                                                                      : r_rd_ptr + 1'b1;
                        n_fill   = r_fill - 1'b1;
                    end else begin
                        n_mode   = MODE_PRELOAD;
                        n_out_en = 1'b0;
                        ev       = EV_UNDERFLOW;
                    end
                end
            end
            REQ_START: begin
                if (r_mode == MODE_READY) begin
                    n_mode = MODE_PRELOAD;
                end else begin
                    ev = EV_REFUSED;
                end
            end
            REQ_STOP: begin
                n_wr_ptr   = '0;
                n_rd_ptr   = '0;
                n_fill     = '0;
                n_mode     = MODE_READY;
                n_chunk_ok = 1'b0;
                n_out_en   = 1'b0;
            end
        endcase

        n_s1.byte_valid    = bv;
        n_s1.mode          = n_mode;
        n_s1.event_code    = ev;
        n_s1.fill_level    = 16'(n_fill);
        n_s1.dropped_count = n_drop;
        n_s1.output_enable = n_out_en;
    end

    aeb_store #(
        .DEPTH (BUFFER_BYTES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && mem_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_data_byte),
        .i_re    (accept && mem_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fill     <= '0;
            r_mode     <= MODE_READY;
            r_drop     <= '0;
            r_chunk_ok <= 1'b0;
            r_out_en   <= 1'b0;
            r_trigger  <= TRIGGER_RESET;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_trigger <= i_cfg_wr_data;
            end
            if (accept) begin
                r_wr_ptr   <= n_wr_ptr;
                r_rd_ptr   <= n_rd_ptr;
                r_fill     <= n_fill;
                r_mode     <= n_mode;
                r_drop     <= n_drop;
                r_chunk_ok <= n_chunk_ok;
                r_out_en   <= n_out_en;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload: advance only on a transfer into the stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_o      <= r_s1;
            r_o_byte <= r_s1.byte_valid ? mem_rdata : '0;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_byte_valid    = r_o.byte_valid;
    assign o_out_byte      = r_o_byte;
    assign o_play_mode     = r_o.mode;
    assign o_event_code    = r_o.event_code;
    assign o_fill_level    = r_o.fill_level;
    assign o_dropped_count = r_o.dropped_count;
    assign o_output_enable = r_o.output_enable;

endmodule

// ----- rtl/aeb_store.sv -----
module aeb_store
    import aeb_pkg::*;
#(
    parameter int unsigned DEPTH = 32768,
    parameter int unsigned AW    = 15
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/aeb_check.sv -----
module aeb_check
    import aeb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_byte_valid,
    input logic [7:0]  o_out_byte,
    input logic [1:0]  o_play_mode,
    input logic [2:0]  o_event_code,
    input logic [15:0] o_fill_level,
    input logic [31:0] o_dropped_count,
    input logic        o_output_enable
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_fill_level) && $stable(o_dropped_count))
        else $error("stalled result changed");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_out_byte == '0)
        else $error("byte nonzero without a delivered byte");

    a_pull_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_valid |->
            o_play_mode == MODE_PLAY || o_play_mode == MODE_DROP)
        else $error("byte delivered while output not running");

    a_enable_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_output_enable |->
            o_play_mode == MODE_PLAY || o_play_mode == MODE_DROP)
        else $error("output enabled outside play or drop");

    a_trigger_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_code == EV_TRIGGERED || o_event_code == EV_HEALED) |->
            o_play_mode == MODE_PLAY)
        else $error("trigger or heal event without play mode");

endmodule

bind audio_elastic_buffer_ctrl_core aeb_check u_aeb_check (.*);

// ----- sim/aeb_buffer_checker.sv -----
module aeb_buffer_checker
    import aeb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_data_byte,
    input  logic        i_chunk_first,
    input  logic        i_chunk_last,
    input  logic [15:0] i_chunk_size,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_byte_valid,
    input  logic [7:0]  i_out_byte,
    input  logic [1:0]  i_play_mode,
    input  logic [2:0]  i_event_code,
    input  logic [15:0] i_fill_level,
    input  logic [31:0] i_dropped_count,
    input  logic        i_output_enable,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BUFFER_BYTES = 32768;

    typedef struct {
        logic        byte_valid;
        logic [7:0]  out_byte;
        t_mode       mode;
        t_event      code;
        logic [15:0] fill;
        logic [31:0] dropped;
        logic        out_en;
    } t_buffer_status;

    logic [7:0]     audio_mem [BUFFER_BYTES];
    logic [14:0]    wr_ptr;
    logic [14:0]    rd_ptr;
    int unsigned    fill;
    t_mode          mode;
    logic [31:0]    drop_total;
    logic           chunk_open;
    logic           out_on;
    logic [15:0]    trigger;
    t_buffer_status status_q [$];
    int             fail_cnt = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic t_buffer_status apply_request(input t_req req, input logic [7:0] data,
                                                     input logic first, input logic last,
                                                     input logic [15:0] size);
        t_buffer_status s;
        logic judged;
        s.byte_valid = 1'b0;
        s.out_byte = 8'h00;
        s.code = EV_NONE;
        judged = 1'b0;
        case (req)
            REQ_PUSH: begin
                if (first) begin
                    judged = 1'b1;
                    if (mode == MODE_DROP) begin
                        // saturate rather than wrap
                        if ({16'd0, size} > 32'hFFFF_FFFF - drop_total)
                            drop_total = 32'hFFFF_FFFF;
                        else
                            drop_total = drop_total + size;
                        chunk_open = 1'b0;
                        if (fill <= trigger) begin
                            mode = MODE_PLAY;
                            s.code = EV_HEALED;
                        end else begin
                            s.code = EV_DISCARDED;
                        end
                    end else if (size <= BUFFER_BYTES - fill) begin
                        chunk_open = 1'b1;
                    end else begin
                        chunk_open = 1'b0;
                        mode = MODE_DROP;
                        drop_total = '0;
                        s.code = EV_OVERFLOW;
                    end
                end
                if (chunk_open) begin
                    if (fill < BUFFER_BYTES) begin
                        audio_mem[wr_ptr] = data;
                        wr_ptr = wr_ptr + 1'b1;
                        fill++;
                    end else begin
                        s.code = EV_DISCARDED;
                    end
                    if (last && mode == MODE_PRELOAD && fill >= trigger) begin
                        mode = MODE_PLAY;
                        out_on = 1'b1;
                        s.code = EV_TRIGGERED;
                    end
                end else if (!judged) begin
                    s.code = EV_DISCARDED;
                end
            end
            REQ_PULL: begin
                if (mode == MODE_PLAY || mode == MODE_DROP) begin
                    if (fill > 0) begin
                        s.byte_valid = 1'b1;
                        s.out_byte = audio_mem[rd_ptr];
                        rd_ptr = rd_ptr + 1'b1;
                        fill--;
                    end else begin
                        mode = MODE_PRELOAD;
                        out_on = 1'b0;
                        s.code = EV_UNDERFLOW;
                    end
                end
            end
            REQ_START: begin
                if (mode == MODE_READY)
                    mode = MODE_PRELOAD;
                else
                    s.code = EV_REFUSED;
            end
            default: begin
                // flush; the drop total survives
                wr_ptr = '0;
                rd_ptr = '0;
                fill = 0;
                mode = MODE_READY;
                chunk_open = 1'b0;
                out_on = 1'b0;
            end
        endcase
        s.mode = mode;
        s.fill = fill[15:0];
        s.dropped = drop_total;
        s.out_en = out_on;
        return s;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : status_monitor
        t_buffer_status want;
        if (!i_rst_n) begin
            wr_ptr = '0;
            rd_ptr = '0;
            fill = 0;
            mode = MODE_READY;
            drop_total = '0;
            chunk_open = 1'b0;
            out_on = 1'b0;
            trigger = TRIGGER_RESET;
            status_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    fail_cnt++;
                end else begin
                    want = status_q.pop_front();
                    check_field("byte_valid", want.byte_valid, i_byte_valid);
                    check_field("out_byte", want.out_byte, i_out_byte);
                    check_field("play_mode", want.mode, i_play_mode);
                    check_field("event_code", want.code, i_event_code);
                    check_field("fill_level", want.fill, i_fill_level);
                    check_field("dropped_count", want.dropped, i_dropped_count);
                    check_field("output_enable", want.out_en, i_output_enable);
                end
            end
            if (i_cfg_wr_en)
                trigger = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall)
                status_q.push_back(apply_request(t_req'(i_req_type), i_data_byte,
                                                 i_chunk_first, i_chunk_last, i_chunk_size));
        end
        o_fail_count <= fail_cnt;
        o_pending <= status_q.size();
    end

endmodule

// ----- sim/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import aeb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 90;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type = '0;
    logic [7:0]  data_byte = '0;
    logic        chunk_first = 1'b0;
    logic        chunk_last = 1'b0;
    logic [15:0] chunk_size = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic [1:0]  play_mode;
    logic [2:0]  event_code;
    logic [15:0] fill_level;
    logic [31:0] dropped_count;
    logic        output_enable;

    int fail_count;
    int pending;
    int items_sent = 0;
    int in_idle_max = 9;
    int out_idle_max = 9;
    bit long_hold_req = 1'b0;

    always #2 clk = ~clk;

    audio_elastic_buffer_ctrl_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_req_type      (req_type),
        .i_data_byte     (data_byte),
        .i_chunk_first   (chunk_first),
        .i_chunk_last    (chunk_last),
        .i_chunk_size    (chunk_size),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_byte_valid    (byte_valid),
        .o_out_byte      (out_byte),
        .o_play_mode     (play_mode),
        .o_event_code    (event_code),
        .o_fill_level    (fill_level),
        .o_dropped_count (dropped_count),
        .o_output_enable (output_enable)
    );

    aeb_buffer_checker i_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_req_type      (req_type),
        .i_data_byte     (data_byte),
        .i_chunk_first   (chunk_first),
        .i_chunk_last    (chunk_last),
        .i_chunk_size    (chunk_size),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_byte_valid    (byte_valid),
        .i_out_byte      (out_byte),
        .i_play_mode     (play_mode),
        .i_event_code    (event_code),
        .i_fill_level    (fill_level),
        .i_dropped_count (dropped_count),
        .i_output_enable (output_enable),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    task automatic send_item(input t_req req, input logic [7:0] data, input logic first,
                             input logic last, input logic [15:0] size);
        int gap;
        gap = $urandom_range(0, in_idle_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        data_byte <= data;
        chunk_first <= first;
        chunk_last <= last;
        chunk_size <= size;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_ctrl(input t_req req);
        send_item(req, 8'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
    endtask

    task automatic send_chunk(input int len, input logic [15:0] declared, input bit with_first,
                              input bit mix_pulls);
        for (int i = 0; i < len; i++) begin
            send_item(REQ_PUSH, 8'($urandom), with_first && i == 0, i == len - 1,
                      i == 0 ? declared : 16'($urandom));
            if (mix_pulls && $urandom_range(0, 4) == 0)
                send_ctrl(REQ_PULL);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // let the last transfer settle in the pipeline
        repeat (6) @(posedge clk);
    endtask

    task automatic write_trigger(input logic [15:0] level);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= level;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_traffic(input int target);
        int pick;
        int len;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 16);
                send_chunk(len, 16'(len), 1'b1, 1'b1);
            end else if (pick < 72) begin
                repeat ($urandom_range(1, 16)) send_ctrl(REQ_PULL);
            end else if (pick < 79) begin
                send_ctrl(REQ_START);
            end else if (pick < 83) begin
                send_ctrl(REQ_STOP);
            end else if (pick < 88) begin
                // declared size can never fit
                send_chunk($urandom_range(1, 3), 16'($urandom_range(32769, 65535)), 1'b1, 1'b1);
            end else if (pick < 92) begin
                send_chunk($urandom_range(1, 5), 16'($urandom_range(0, 30)), 1'b1, 1'b1);
            end else if (pick < 95) begin
                send_chunk($urandom_range(1, 5), 16'($urandom), 1'b0, 1'b1);
            end else begin
                send_item(t_req'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                          1'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin : out_side
        int gap;
        forever begin
            if (long_hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
            end
            gap = $urandom_range(0, out_idle_max);
            if (gap > 0) begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset trigger level
        send_ctrl(REQ_PULL);
        send_item(REQ_PUSH, 8'h00, 1'b1, 1'b0, 16'd2);
        send_item(REQ_PUSH, 8'hFF, 1'b0, 1'b1, 16'd0);
        send_ctrl(REQ_STOP);
        send_ctrl(REQ_START);
        send_ctrl(REQ_START);
        send_item(REQ_PUSH, 8'h3C, 1'b1, 1'b0, 16'hFFFF);
        send_item(REQ_PUSH, 8'hC3, 1'b0, 1'b1, 16'h0000);
        send_item(REQ_PUSH, 8'h11, 1'b1, 1'b1, 16'd0);
        send_ctrl(REQ_PULL);
        send_ctrl(REQ_PULL);
        send_item(REQ_PUSH, 8'hA5, 1'b1, 1'b1, 16'd1);
        send_ctrl(REQ_STOP);

        write_trigger(16'd0);
        send_ctrl(REQ_START);
        send_item(REQ_PUSH, 8'h5A, 1'b1, 1'b0, 16'd2);
        send_item(REQ_PUSH, 8'hE7, 1'b0, 1'b1, 16'd2);
        send_ctrl(REQ_PULL);
        send_item(REQ_PUSH, 8'h81, 1'b1, 1'b1, 16'hAAAA);
        send_item(REQ_PUSH, 8'h7E, 1'b1, 1'b1, 16'h5555);
        send_ctrl(REQ_PULL);
        send_item(REQ_PUSH, 8'h24, 1'b1, 1'b1, 16'd5);
        send_ctrl(REQ_PULL);
        send_ctrl(REQ_STOP);

        for (int p = 0; p < 4; p++) begin
            write_trigger(p == 2 ? 16'($urandom_range(40, 300)) : 16'($urandom_range(0, 12)));
            if (p == 0 || p == 2)
                long_hold_req = 1'b1;
            random_traffic(items_sent + 280);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/aeb_pkg.sv
rtl/aeb_store.sv
rtl/audio_elastic_buffer_ctrl_core.sv
rtl/aeb_check.sv
sim/aeb_buffer_checker.sv
sim/testbench.sv
